// ===== rtl/core/lscd_pkg.sv =====
// Package for the limited-stock change dispenser.
// Holds the denomination table, the hand-down factors and the shared types.
// No dependencies; imported by every module of the block.
package lscd_pkg;

  localparam int NUM_DENOMS     = 8;
  localparam int STOCK_BITS     = 16;
  localparam int CFG_INDEX_BITS = 3;

  typedef logic [STOCK_BITS-1:0] stock_t;
  typedef stock_t [NUM_DENOMS-1:0] count_vec_t;

  // Face value of each denomination, largest first.
  function automatic int denom_value(input int idx);
    case (idx)
      0:       return 1000;
      1:       return 500;
      2:       return 100;
      3:       return 50;
      4:       return 20;
      5:       return 10;
      6:       return 5;
      default: return 1;
    endcase
  endfunction

  // Pieces of the next smaller denomination that replace one surplus piece.
  function automatic int factor_next(input int idx);
    case (idx)
      0:       return 2;
      1:       return 5;
      2:       return 2;
      3:       return 2;
      4:       return 2;
      5:       return 2;
      6:       return 5;
      default: return 0;
    endcase
  endfunction

  // Pieces two denominations down that replace one surplus piece.
  // Only a fifty is broken into twenties and a ten.
  function automatic int factor_skip(input int idx);
    case (idx)
      3:       return 1;
      default: return 0;
    endcase
  endfunction

  // Width of a remainder left after dividing by a denomination.
  function automatic int rem_bits(input int idx);
    int d;
    d = denom_value(idx);
    return (d > 1) ? $clog2(d) : 1;
  endfunction

endpackage

// ===== rtl/core/lscd_cell.sv =====
// One cell of the dispenser chain: greedy split for one denomination,
// then the clamp to stock with the surplus handed down the chain.
// Depends on lscd_pkg.
module lscd_cell
  import lscd_pkg::*;
#(
  parameter int AMOUNT_BITS = 20,
  parameter int IN_BITS     = 20,
  parameter int DENOM       = 1000,
  parameter int FACTOR_NEXT = 2,
  parameter int FACTOR_SKIP = 0,
  parameter int SLOT        = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [AMOUNT_BITS-1:0] in_rest,
  input  logic [AMOUNT_BITS-1:0] in_pass_a,
  input  logic [AMOUNT_BITS-1:0] in_pass_b,
  input  count_vec_t             in_counts,
  input  stock_t                 stock,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [AMOUNT_BITS-1:0] out_rest,
  output logic [AMOUNT_BITS-1:0] out_pass_a,
  output logic [AMOUNT_BITS-1:0] out_pass_b,
  output count_vec_t             out_counts,
  output logic                   out_over
);

  localparam int REM_BITS = (DENOM > 1) ? $clog2(DENOM) : 1;
  localparam int CMP_BITS = (AMOUNT_BITS > STOCK_BITS) ? AMOUNT_BITS : STOCK_BITS;
  localparam logic [IN_BITS-1:0]     DEN_IN  = IN_BITS'(DENOM);
  localparam logic [REM_BITS-1:0]    DEN_REM = REM_BITS'(DENOM);
  localparam logic [AMOUNT_BITS-1:0] FN_A    = AMOUNT_BITS'(FACTOR_NEXT);
  localparam logic [AMOUNT_BITS-1:0] FS_A    = AMOUNT_BITS'(FACTOR_SKIP);

  // Stage enables: a stage moves when it is empty or its successor moves.
  logic v1, v2, v3;
  logic en1, en2, en3;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // Stage one: reciprocal estimate of the quotient.
  logic [IN_BITS-1:0]     rest1;
  logic [AMOUNT_BITS-1:0] pa1, pb1;
  count_vec_t             counts1;
  logic [IN_BITS-1:0]     q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      rest1   <= in_rest[IN_BITS-1:0];
      pa1     <= in_pass_a;
      pb1     <= in_pass_b;
      counts1 <= in_counts;
    end
  end

  if (DENOM > 1) begin : g_div
    // The floor of 2^IN_BITS / DENOM underestimates the quotient by at most one.
    localparam logic [63:0]        RECIP_WIDE = (64'd1 << IN_BITS) / 64'(DENOM);
    localparam logic [IN_BITS-1:0] RECIP      = RECIP_WIDE[IN_BITS-1:0];

    logic [2*IN_BITS-1:0] prod;
    logic [2*IN_BITS-1:0] prod_next;

    assign prod_next = (2*IN_BITS)'(in_rest[IN_BITS-1:0]) * (2*IN_BITS)'(RECIP);

    always_ff @(posedge clk) begin
      if (en1) begin
        prod <= prod_next;
      end
    end

    assign q0 = prod[2*IN_BITS-1:IN_BITS];
  end else begin : g_unit
    assign q0 = rest1;
  end

  // Stage two: correct the estimate and add the pieces handed down.
  logic [IN_BITS-1:0]     qd, r0, q, r;
  logic                   fix;
  logic [AMOUNT_BITS-1:0] total_next;

  always_comb begin
    qd         = q0 * DEN_IN;
    r0         = rest1 - qd;
    fix        = (r0 >= DEN_IN);
    q          = fix ? (q0 + 1'b1) : q0;
    r          = fix ? (r0 - DEN_IN) : r0;
    total_next = AMOUNT_BITS'(q) + pa1;
  end

  logic [REM_BITS-1:0]    r2;
  logic [AMOUNT_BITS-1:0] total2, pb2;
  count_vec_t             counts2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      r2      <= REM_BITS'(r);
      total2  <= total_next;
      pb2     <= pb1;
      counts2 <= counts1;
    end
  end

  // Stage three: clamp to stock and hand the surplus down.
  logic                   over;
  logic [AMOUNT_BITS-1:0] ex;
  logic [AMOUNT_BITS-1:0] pass_a_next, pass_b_next;
  count_vec_t             counts_next;

  always_comb begin
    over        = CMP_BITS'(total2) > CMP_BITS'(stock);
    ex          = over ? AMOUNT_BITS'(CMP_BITS'(total2) - CMP_BITS'(stock)) : '0;
    pass_a_next = pb2 + ex * FN_A;
    pass_b_next = ex * FS_A;
    counts_next = counts2;
    counts_next[SLOT] = over ? stock : STOCK_BITS'(total2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_rest   <= AMOUNT_BITS'(r2);
      out_pass_a <= pass_a_next;
      out_pass_b <= pass_b_next;
      out_counts <= counts_next;
      out_over   <= over;
    end
  end

  assign out_valid = v3;

  // The corrected remainder is always below the denomination.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (r2 < DEN_REM))
    else $error("remainder not below denomination");

  // Quotient and remainder together give back the value that entered.
  a_split_exact: assert property (@(posedge clk) disable iff (rst)
    (v1 && en2) |=> (64'(total2 - $past(pa1)) * 64'(DENOM) + 64'(r2)
                     == 64'($past(rest1))))
    else $error("greedy split lost value");

  // Without surplus nothing is handed two denominations down.
  a_no_surplus: assert property (@(posedge clk) disable iff (rst)
    (v3 && !out_over) |-> (out_pass_b == '0))
    else $error("surplus handed down without overflow");

  // A count never exceeds the stock of its denomination.
  a_within_stock: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (out_counts[SLOT] <= stock))
    else $error("count above stock");

endmodule

// ===== rtl/core/limited_stock_change_dispenser.sv =====
// Top level of the limited-stock change dispenser.
// Holds the stock registers, the chain of lscd_cell instances and the output
// register. Depends on lscd_pkg and lscd_cell.
//
// The block splits each amount greedily into 1000, 500, 100, 50, 20, 10, 5
// and 1 unit pieces, caps each count at the configured stock and breaks the
// surplus into smaller pieces; if the one-unit coins then needed exceed their
// stock, all counts are zero and shortage is set. It accepts one amount per
// clock cycle when the output side does not stall. Each of the eight
// denomination cells is a pipeline of a reciprocal multiply, a quotient
// correction and the stock clamp, and the output register comes last. Every
// stage has its own valid bit, so empty stages fill while a finished result
// waits to be taken. Stock registers are written through cfg_write,
// cfg_index and cfg_data and reset to zero; they should be written only
// while no transaction is in flight.
module limited_stock_change_dispenser
  import lscd_pkg::*;
#(
  parameter int AMOUNT_BITS = 20,
  parameter int COUNT_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  stock_t                    cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [AMOUNT_BITS-1:0]    amount,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [COUNT_BITS-1:0]     count_thousand,
  output logic [COUNT_BITS-1:0]     count_five_hundred,
  output logic [COUNT_BITS-1:0]     count_hundred,
  output logic [COUNT_BITS-1:0]     count_fifty,
  output logic [COUNT_BITS-1:0]     count_twenty,
  output logic [COUNT_BITS-1:0]     count_ten,
  output logic [COUNT_BITS-1:0]     count_five,
  output logic [COUNT_BITS-1:0]     count_one,
  output logic                      shortage
);

  localparam int SAT_BITS = (COUNT_BITS > STOCK_BITS) ? COUNT_BITS : STOCK_BITS;
  localparam logic [SAT_BITS-1:0] COUNT_MAX = SAT_BITS'((64'd1 << COUNT_BITS) - 64'd1);

  // Stock registers, one per denomination.
  stock_t [NUM_DENOMS-1:0] stock;

  always_ff @(posedge clk) begin
    if (rst) begin
      stock <= '0;
    end else if (cfg_write) begin
      stock[cfg_index] <= cfg_data;
    end
  end

  // Links between neighbouring cells.
  logic                   valid_c  [NUM_DENOMS+1];
  logic                   ready_c  [NUM_DENOMS+1];
  logic [AMOUNT_BITS-1:0] rest_c   [NUM_DENOMS+1];
  logic [AMOUNT_BITS-1:0] pa_c     [NUM_DENOMS+1];
  logic [AMOUNT_BITS-1:0] pb_c     [NUM_DENOMS+1];
  count_vec_t             counts_c [NUM_DENOMS+1];
  logic                   over_c   [NUM_DENOMS];

  assign valid_c[0]  = in_valid;
  assign in_ready    = ready_c[0];
  assign rest_c[0]   = amount;
  assign pa_c[0]     = '0;
  assign pb_c[0]     = '0;
  assign counts_c[0] = '0;

  for (genvar k = 0; k < NUM_DENOMS; k++) begin : g_cell
    lscd_cell #(
      .AMOUNT_BITS (AMOUNT_BITS),
      .IN_BITS     ((k == 0) ? AMOUNT_BITS : rem_bits(k - 1)),
      .DENOM       (denom_value(k)),
      .FACTOR_NEXT (factor_next(k)),
      .FACTOR_SKIP (factor_skip(k)),
      .SLOT        (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (valid_c[k]),
      .in_ready   (ready_c[k]),
      .in_rest    (rest_c[k]),
      .in_pass_a  (pa_c[k]),
      .in_pass_b  (pb_c[k]),
      .in_counts  (counts_c[k]),
      .stock      (stock[k]),
      .out_valid  (valid_c[k+1]),
      .out_ready  (ready_c[k+1]),
      .out_rest   (rest_c[k+1]),
      .out_pass_a (pa_c[k+1]),
      .out_pass_b (pb_c[k+1]),
      .out_counts (counts_c[k+1]),
      .out_over   (over_c[k])
    );
  end

  // Output register: zero on shortage, otherwise saturate to the count width.
  logic                  en_o;
  logic                  short_next;
  logic [COUNT_BITS-1:0] fmt      [NUM_DENOMS];
  logic [COUNT_BITS-1:0] count_r  [NUM_DENOMS];
  logic [SAT_BITS-1:0]   wide     [NUM_DENOMS];

  assign en_o                = !out_valid || out_ready;
  assign ready_c[NUM_DENOMS] = en_o;
  assign short_next          = over_c[NUM_DENOMS-1];

  always_comb begin
    for (int i = 0; i < NUM_DENOMS; i++) begin
      wide[i] = SAT_BITS'(counts_c[NUM_DENOMS][i]);
      if (short_next) begin
        fmt[i] = '0;
      end else begin
        fmt[i] = COUNT_BITS'((wide[i] > COUNT_MAX) ? COUNT_MAX : wide[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_o) begin
      out_valid <= valid_c[NUM_DENOMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      count_r  <= fmt;
      shortage <= short_next;
    end
  end

  assign count_thousand     = count_r[0];
  assign count_five_hundred = count_r[1];
  assign count_hundred      = count_r[2];
  assign count_fifty        = count_r[3];
  assign count_twenty       = count_r[4];
  assign count_ten          = count_r[5];
  assign count_five         = count_r[6];
  assign count_one          = count_r[7];

endmodule
